FILE: sv/rtiq_pkg.sv
// Shared types and constants for the real-to-I/Q quarter-rate converter.
// Used by every module of the block; depends on nothing.
package rtiq_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TAP_PAIRS  = 16;
  localparam int TAP_AW     = $clog2(TAP_PAIRS);
  localparam int HIST_LEN   = 2 * TAP_PAIRS;
  localparam int HIST_AW    = $clog2(HIST_LEN);
  localparam int Q_DEPTH    = 16;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);
  localparam int ALPHA_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [ALPHA_W-1:0] DC_ALPHA_RESET = 15'd32440;

  localparam logic [CFG_IDX_W-1:0] REG_DC_ALPHA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D   = 3'd4;

  typedef logic [TAP_PAIRS-1:0][SAMPLE_W-1:0] coef_bank_t;

  typedef struct packed {
    logic                quad;
    logic [SAMPLE_W-1:0] value;
  } rtiq_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_DONE
  } bk_state_t;

endpackage

FILE: sv/rtiq_front.sv
// Front end: DC-removal high-pass and fs/4 mixing of each accepted sample.
// Emits one classified item (I history push or Q delay push). Uses rtiq_pkg.
module rtiq_front import rtiq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [ALPHA_W-1:0]         dc_alpha,
  output rtiq_item_t                 item
);

  logic [1:0]          phase;
  logic [SAMPLE_W-1:0] prev_input;
  logic [SAMPLE_W-1:0] prev_output;
  logic [31:0]         dc_remainder;

  logic signed [31:0]  prod;
  logic [31:0]         u;
  logic [SAMPLE_W-1:0] s;
  logic [SAMPLE_W-1:0] y;
  logic [31:0]         remainder_next;
  logic [SAMPLE_W:0]   neg;

  always_comb begin
    prod = $signed(prev_output) * $signed({1'b0, dc_alpha});
    u = dc_remainder + prod;
    s = u[30:15];
    y = sample_in - prev_input + s;
    remainder_next = u - {s[15], s, 15'd0};
    neg = 17'd0 - {y[15], y};
    item.quad = phase[0];
    case (phase)
      2'd0: item.value = neg[15:0];
      2'd1: item.value = neg[16:1];
      2'd2: item.value = y;
      2'd3: item.value = {y[15], y[15:1]};
      default: item.value = y;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      prev_input   <= '0;
      prev_output  <= '0;
      dc_remainder <= '0;
    end else if (accept) begin
      phase        <= phase + 2'd1;
      prev_input   <= sample_in;
      prev_output  <= y;
      dc_remainder <= remainder_next;
    end
  end

endmodule

FILE: sv/rtiq_queue.sv
// Short queue of classified items between the front end and the back end.
// Uses rtiq_pkg for the item type and depth.
module rtiq_queue import rtiq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rtiq_item_t item_in,
  output logic       full,
  input  logic       pop,
  output rtiq_item_t item_out,
  output logic       empty
);

  rtiq_item_t            slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full     = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign item_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/rtiq_back.sv
// Back end: I history with a one-multiplier symmetric FIR sequencer, the Q
// delay line, and the output register. Uses rtiq_pkg.
module rtiq_back import rtiq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  rtiq_item_t           item,
  input  logic                 item_empty,
  output logic                 item_pop,
  input  coef_bank_t           coef,
  output logic [SAMPLE_W-1:0]  sample_out,
  output logic                 is_quadrature,
  output logic                 empty,
  input  logic                 pop
);

  bk_state_t state;
  bk_state_t state_next;

  logic [SAMPLE_W-1:0] hist_mem [HIST_LEN];
  logic [HIST_LEN-1:0] hist_vld;
  logic [HIST_AW-1:0]  hist_head;
  logic [HIST_AW-1:0]  wr_addr;
  logic [HIST_AW-1:0]  addr_a;
  logic [HIST_AW-1:0]  addr_b;
  logic [SAMPLE_W-1:0] rd_a;
  logic [SAMPLE_W-1:0] rd_b;

  logic [TAP_AW-1:0]   k;
  logic                s1_vld;
  logic [TAP_AW-1:0]   s1_k;
  logic                s2_vld;
  logic [31:0]         prod;
  logic [31:0]         acc;
  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [2*SAMPLE_W:0] prod_full;

  logic [SAMPLE_W-1:0] q_line [Q_DEPTH];
  logic [Q_AW-1:0]     q_head;

  logic out_vld;
  logic out_free;
  logic q_op;
  logic i_start;
  logic issue;
  logic i_load;

  assign empty    = !out_vld;
  assign out_free = !out_vld || pop;
  assign wr_addr  = hist_head - 1'b1;
  assign addr_a   = hist_head + HIST_AW'(k);
  assign addr_b   = hist_head - 1'b1 - HIST_AW'(k);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (!item_empty && !item.quad) state_next = BK_RUN;
      BK_RUN:   if (k == TAP_AW'(TAP_PAIRS - 1)) state_next = BK_DRAIN;
      BK_DRAIN: if (!s1_vld && !s2_vld) state_next = BK_DONE;
      BK_DONE:  if (out_free) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    item_pop = 1'b0;
    q_op     = 1'b0;
    i_start  = 1'b0;
    issue    = 1'b0;
    i_load   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!item_empty) begin
          if (item.quad) begin
            item_pop = out_free;
            q_op     = out_free;
          end else begin
            item_pop = 1'b1;
            i_start  = 1'b1;
          end
        end
      end
      BK_RUN:   issue  = 1'b1;
      BK_DONE:  i_load = out_free;
      default:  issue  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (i_start) begin
      hist_mem[wr_addr] <= item.value;
    end
    rd_a <= hist_vld[addr_a] ? hist_mem[addr_a] : '0;
    rd_b <= hist_vld[addr_b] ? hist_mem[addr_b] : '0;
  end

  always_comb begin
    pair_sum  = $signed({rd_a[SAMPLE_W-1], rd_a}) + $signed({rd_b[SAMPLE_W-1], rd_b});
    prod_full = $signed(coef[s1_k]) * pair_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld  <= '0;
      hist_head <= '0;
      k         <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      q_head    <= '0;
      out_vld   <= 1'b0;
    end else begin
      if (i_start) begin
        hist_vld[wr_addr] <= 1'b1;
        hist_head         <= wr_addr;
      end
      k      <= issue ? k + 1'b1 : '0;
      s1_vld <= issue;
      s2_vld <= s1_vld;
      if (q_op) begin
        q_head <= q_head + 1'b1;
      end
      if (q_op || i_load) begin
        out_vld <= 1'b1;
      end else if (pop) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_k <= k;
    prod <= prod_full[31:0];
    if (i_start) begin
      acc <= '0;
    end else if (s2_vld) begin
      acc <= acc + prod;
    end
    if (q_op) begin
      sample_out    <= q_line[q_head];
      is_quadrature <= 1'b1;
    end else if (i_load) begin
      sample_out    <= acc[30:15];
      is_quadrature <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Q_DEPTH; i++) begin
        q_line[i] <= '0;
      end
    end else if (q_op) begin
      q_line[q_head] <= item.value;
    end
  end

endmodule

FILE: sv/real_to_iq_quarter_rate_converter_top.sv
// Top level of the real-to-I/Q quarter-rate converter with its config registers.
// Instantiates rtiq_front, rtiq_queue and rtiq_back; uses rtiq_pkg.
//
// Real samples enter on a queue-style port: a beat is taken when push is high
// and full is low. Results leave the same way: sample_out and is_quadrature
// hold the oldest result while empty is low, and a beat leaves when pop is high.
// Every input beat gives exactly one result, I and Q interleaved.
// Configuration writes use cfg_valid/cfg_ready (always ready) with cfg_index
// and cfg_data; they are meant for idle periods only.
// The front end filters and mixes one sample per cycle, while full is low, into a four-entry queue.
// A Q result passes through the queue and is loaded into the output register
// once the back end is idle and the output register is free. An I result
// steps one multiplier through the 16 tap pairs and occupies the back end
// through its run, drain and done states before it takes the next item.
// A full output register stalls the back end; the front end keeps accepting
// until the queue fills. Reset clears all filter state and restores the
// register defaults; the first beat can follow right after reset.
module real_to_iq_quarter_rate_converter_top import rtiq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       is_quadrature,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  logic [ALPHA_W-1:0]  dc_alpha;
  coef_bank_t          coef;
  rtiq_item_t          front_item;
  rtiq_item_t          queue_item;
  logic                accept;
  logic                queue_empty;
  logic                queue_pop;
  logic [SAMPLE_W-1:0] back_sample;

  assign cfg_ready  = 1'b1;
  assign accept     = push && !full;
  assign sample_out = back_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_alpha <= DC_ALPHA_RESET;
      coef     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DC_ALPHA: dc_alpha     <= cfg_data[ALPHA_W-1:0];
        REG_COEF_A:   coef[3:0]    <= cfg_data;
        REG_COEF_B:   coef[7:4]    <= cfg_data;
        REG_COEF_C:   coef[11:8]   <= cfg_data;
        REG_COEF_D:   coef[15:12]  <= cfg_data;
        default:      dc_alpha     <= dc_alpha;
      endcase
    end
  end

  rtiq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sample_in (sample_in),
    .dc_alpha  (dc_alpha),
    .item      (front_item)
  );

  rtiq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .item_in  (front_item),
    .full     (full),
    .pop      (queue_pop),
    .item_out (queue_item),
    .empty    (queue_empty)
  );

  rtiq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (queue_item),
    .item_empty    (queue_empty),
    .item_pop      (queue_pop),
    .coef          (coef),
    .sample_out    (back_sample),
    .is_quadrature (is_quadrature),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

FILE: bench/rtiq_checker.sv
// Scoreboard for the real-to-I/Q quarter-rate converter: watches the sample, result and
// register-write channels, predicts every result and compares it field by field.
// Depends on rtiq_pkg for widths, register indexes and the result type.
module rtiq_checker import rtiq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  logic [SAMPLE_W-1:0]   sample_in,
  input  logic                  pop,
  input  logic                  empty,
  input  logic [SAMPLE_W-1:0]   sample_out,
  input  logic                  is_quadrature,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    MIX_I_NEG,
    MIX_Q_NEG,
    MIX_I_POS,
    MIX_Q_POS
  } mix_step_t;

  logic [ALPHA_W-1:0]  alpha_q15;
  coef_bank_t          tap_coef;
  mix_step_t           mix_step;
  logic [SAMPLE_W-1:0] last_sample;
  logic [SAMPLE_W-1:0] last_filtered;
  logic [31:0]         dc_frac;
  logic [SAMPLE_W-1:0] i_taps [HIST_LEN];
  logic [HIST_AW-1:0]  i_tap_head;
  logic [SAMPLE_W-1:0] q_line [Q_DEPTH];
  logic [Q_AW-1:0]     q_line_head;

  rtiq_item_t expected_iq [$];
  int mismatches = 0;
  int waiting = 0;

  assign fail_count  = mismatches;
  assign outstanding = waiting;

  function automatic logic [31:0] widen(input logic [SAMPLE_W-1:0] v);
    return {{(32-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  function automatic logic [SAMPLE_W-1:0] i_fir(input logic [SAMPLE_W-1:0] v);
    logic [31:0] acc;
    logic [HIST_AW-1:0] lo, hi;
    i_tap_head = i_tap_head - 1'b1;
    i_taps[i_tap_head] = v;
    acc = '0;
    for (int k = 0; k < TAP_PAIRS; k++) begin
      lo = i_tap_head + HIST_AW'(k);
      hi = i_tap_head - HIST_AW'(k) - 1'b1;
      acc = acc + widen(tap_coef[k]) * (widen(i_taps[lo]) + widen(i_taps[hi]));
    end
    return acc[30:15];
  endfunction

  function automatic logic [SAMPLE_W-1:0] q_delay(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] old;
    old = q_line[q_line_head];
    q_line[q_line_head] = v;
    q_line_head = q_line_head + 1'b1;
    return old;
  endfunction

  function automatic rtiq_item_t filter_and_mix(input logic [SAMPLE_W-1:0] x);
    logic [31:0] u, s32, y32, neg32;
    logic [SAMPLE_W-1:0] y16;
    rtiq_item_t r;
    u = dc_frac + widen(last_filtered) * {{(32-ALPHA_W){1'b0}}, alpha_q15};
    s32 = widen(u[30:15]);
    y16 = x - last_sample + s32[SAMPLE_W-1:0];
    dc_frac = u - (s32 << 15);
    last_sample = x;
    last_filtered = y16;
    y32 = widen(y16);
    neg32 = 32'd0 - y32;
    case (mix_step)
      MIX_I_NEG: begin
        r.quad = 1'b0;
        r.value = i_fir(neg32[SAMPLE_W-1:0]);
      end
      MIX_Q_NEG: begin
        r.quad = 1'b1;
        r.value = q_delay(neg32[SAMPLE_W:1]);
      end
      MIX_I_POS: begin
        r.quad = 1'b0;
        r.value = i_fir(y16);
      end
      default: begin
        r.quad = 1'b1;
        r.value = q_delay(y32[SAMPLE_W:1]);
      end
    endcase
    mix_step = mix_step_t'(mix_step + 1'b1);
    return r;
  endfunction

  always @(posedge clk) begin
    rtiq_item_t exp_item;
    if (rst) begin
      alpha_q15 = DC_ALPHA_RESET;
      tap_coef = '0;
      mix_step = MIX_I_NEG;
      last_sample = '0;
      last_filtered = '0;
      dc_frac = '0;
      for (int i = 0; i < HIST_LEN; i++) i_taps[i] = '0;
      i_tap_head = '0;
      for (int i = 0; i < Q_DEPTH; i++) q_line[i] = '0;
      q_line_head = '0;
      expected_iq.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DC_ALPHA: alpha_q15 = cfg_data[ALPHA_W-1:0];
          REG_COEF_A, REG_COEF_B, REG_COEF_C, REG_COEF_D: begin
            for (int j = 0; j < 4; j++)
              tap_coef[(cfg_index - REG_COEF_A) * 4 + j] = cfg_data[j*SAMPLE_W +: SAMPLE_W];
          end
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_iq.size() == 0) begin
          $error("Unexpected result beat: sample_out %0d, is_quadrature %0d",
                 $signed(sample_out), is_quadrature);
          mismatches++;
        end else begin
          exp_item = expected_iq.pop_front();
          if (sample_out !== exp_item.value) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   $signed(exp_item.value), $signed(sample_out));
            mismatches++;
          end
          if (is_quadrature !== exp_item.quad) begin
            $error("is_quadrature mismatch: expected %0d, actual %0d",
                   exp_item.quad, is_quadrature);
            mismatches++;
          end
        end
      end
      if (push && !full) expected_iq.push_back(filter_and_mix(sample_in));
    end
    waiting = expected_iq.size();
  end
endmodule

FILE: bench/testbench.sv
// Stimulus and verdict for the real-to-I/Q quarter-rate converter: directed extremes,
// then randomized samples under several register settings with random back-pressure.
// Depends on rtiq_pkg, real_to_iq_quarter_rate_converter_top and rtiq_checker.
module testbench import rtiq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_SETS = 6;
  localparam int SET_ITEMS   = 150;

  localparam logic [SAMPLE_W-1:0] WARMUP [4] = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF};
  localparam logic [SAMPLE_W-1:0] DIRECTED_A [10] = '{
    16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h7FFF,
    16'h8000, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000};
  localparam logic [SAMPLE_W-1:0] DIRECTED_B [10] = '{
    16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [SAMPLE_W-1:0]   sample_in = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [SAMPLE_W-1:0]   sample_out;
  logic                  is_quadrature;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DC_ALPHA;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int settings = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  real_to_iq_quarter_rate_converter_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample_in(sample_in),
    .empty(empty), .pop(pop), .sample_out(sample_out), .is_quadrature(is_quadrature),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  rtiq_checker scoreboard (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample_in(sample_in),
    .pop(pop), .empty(empty), .sample_out(sample_out), .is_quadrature(is_quadrature),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .outstanding(outstanding)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      1, 2, 3: return SAMPLE_W'($urandom_range(0, 511) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_coefs(input int mode);
    logic [CFG_DATA_W-1:0] p;
    for (int f = 0; f < 4; f++) begin
      case (mode)
        0: p[f*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(0, 2047) - 1024);
        1: p[f*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom);
        default: begin
          case ($urandom_range(0, 2))
            0: p[f*SAMPLE_W +: SAMPLE_W] = 16'h7FFF;
            1: p[f*SAMPLE_W +: SAMPLE_W] = 16'h8000;
            default: p[f*SAMPLE_W +: SAMPLE_W] = 16'h0000;
          endcase
        end
      endcase
    end
    return p;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    int gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? idle_len() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    sample_in <= v;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic program_regs(input logic [ALPHA_W-1:0] alpha,
                              input logic [CFG_DATA_W-1:0] pa, pb, pc, pd);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{REG_DC_ALPHA, REG_COEF_A, REG_COEF_B, REG_COEF_C, REG_COEF_D,
            CFG_IDX_W'($urandom_range(REG_COEF_D + 1, 2**CFG_IDX_W - 1))};
    val = '{{(CFG_DATA_W-ALPHA_W)'({$urandom, $urandom}), alpha}, pa, pb, pc, pd,
            CFG_DATA_W'({$urandom, $urandom})};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        pop <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
        $display("real_to_iq_quarter_rate_converter_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [ALPHA_W-1:0] alpha;
    int r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct = 20;

    foreach (WARMUP[i]) send_sample(WARMUP[i]);
    settle();
    program_regs('0, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    foreach (DIRECTED_A[i]) send_sample(DIRECTED_A[i]);
    settle();
    program_regs('1, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    foreach (DIRECTED_B[i]) send_sample(DIRECTED_B[i]);

    for (int p = 0; p < RANDOM_SETS; p++) begin
      settle();
      r = $urandom_range(0, 3);
      alpha = (r == 0) ? '0 : (r == 1) ? '1 : ALPHA_W'($urandom);
      r = $urandom_range(0, 2);
      program_regs(alpha, rand_coefs(r), rand_coefs(r), rand_coefs(r), rand_coefs(r));
      for (int n = 0; n < SET_ITEMS; n++) begin
        if (n % 50 == 0) begin
          case ($urandom_range(0, 2))
            0: tx_idle_pct = 0;
            1: tx_idle_pct = 15;
            default: tx_idle_pct = 50;
          endcase
          case ($urandom_range(0, 2))
            0: rx_idle_pct = 0;
            1: rx_idle_pct = 15;
            default: rx_idle_pct = 50;
          endcase
          if (p == 1 && n == 0) begin
            tx_idle_pct = 0;
            hold_req = 1'b1;
          end
        end
        send_sample(rand_sample());
      end
    end

    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (50) @(posedge clk);
    $display("Run covered %0d samples under %0d register settings, including extremes,",
             items_sent, settings);
    $display("random idle gaps on both channels and a long output stall.");
    if (fail_count == 0)
      $display("real_to_iq_quarter_rate_converter_top verification clean");
    else
      $display("real_to_iq_quarter_rate_converter_top verification failed");
    $finish;
  end
endmodule

FILE: files.f
sv/rtiq_pkg.sv
sv/rtiq_front.sv
sv/rtiq_queue.sv
sv/rtiq_back.sv
sv/real_to_iq_quarter_rate_converter_top.sv
bench/rtiq_checker.sv
bench/testbench.sv
